// ----- hw/rtl/plarf_pkg.sv -----
package plarf_pkg;

    // Store geometry
    localparam int DEPTH = 16;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;

    // Result field widths
    localparam int POS_W = 4;
    localparam int ITEM_CNT_W = 5;

    // Request codes
    localparam logic [1:0] REQ_APPEND = 2'd0;
    localparam logic [1:0] REQ_REMOVE = 2'd1;
    localparam logic [1:0] REQ_FIND   = 2'd2;

    // Status codes
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [1:0] STAT_FULL      = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [1:0]               req_type;
        logic signed [DATA_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic [1:0]            status;
        logic [POS_W-1:0]      position;
        logic [ITEM_CNT_W-1:0] item_count;
    } res_t;

    // Store port controls from the sequencer
    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [DATA_W-1:0] wdata;
        logic [IDX_W-1:0]  raddr;
    } mem_ctl_t;

endpackage

// ----- hw/rtl/plarf_store.sv -----
module plarf_store
    import plarf_pkg::*;
(
    input  logic              aclk,
    input  mem_ctl_t          ctl,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    // Write one entry, read one entry into the output register
    always_ff @(posedge aclk) begin
        if (ctl.we) begin
            mem[ctl.waddr] <= ctl.wdata;
        end
        rd_data <= mem[ctl.raddr];
    end

endmodule

// ----- hw/rtl/packed_list_append_remove_find_core.sv -----
// Packed list of signed 32-bit values with append, remove and find requests.
// Input channel s_valid/s_ready/s_data carries one request (req_type, value);
// result channel m_valid/m_ready/m_data returns exactly one result per request
// (status, position, item_count). Requests are served one at a time; s_ready
// is high only while the sequencer is idle.
// Append and the unused code go straight to the result, as do find and
// remove on an empty list; find scans from index 0 up to the first match or
// the last entry; remove scans the same way and then shifts every entry
// above the match down one place.
// The store has a single read port and a single write port, so the scan
// visits one entry per cycle and the shift moves one entry per cycle.
// Reset clears the count, the sequencer and the result valid flag; entries
// above the count are never read, so the store itself needs no clearing.
// A finished result waits in the output register while m_ready is low; the
// next request may be taken meanwhile, but its result waits until the
// register is free.
module packed_list_append_remove_find_core
    import plarf_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  req_t s_data,
    output logic m_valid,
    input  logic m_ready,
    output res_t m_data
);

    state_t            state_reg, state_next;
    req_t              req_reg, req_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [IDX_W-1:0]  pos_reg, pos_next;
    logic [1:0]        status_reg, status_next;
    logic              m_valid_reg, m_valid_next;
    res_t              m_data_reg, m_data_next;
    mem_ctl_t          mem_ctl;
    logic [DATA_W-1:0] rd_data;

    logic              in_xfer;
    logic              hit;
    logic              last_scan;
    logic              shift_more;
    logic              out_free;
    logic              list_full;
    logic              list_empty;

    plarf_store u_store (
        .aclk    (aclk),
        .ctl     (mem_ctl),
        .rd_data (rd_data)
    );

    // Shared conditions
    assign in_xfer    = s_valid && s_ready;
    assign hit        = (rd_data == req_reg.value);
    assign last_scan  = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);
    assign shift_more = ((CNT_W'(idx_reg) + CNT_W'(1)) < count_reg);
    assign out_free   = !m_valid_reg || m_ready;
    assign list_full  = (count_reg == CNT_W'(DEPTH));
    assign list_empty = (count_reg == '0);

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    if ((s_data.req_type == REQ_REMOVE || s_data.req_type == REQ_FIND)
                        && !list_empty) begin
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SCAN: begin
                if (hit && req_reg.req_type == REQ_REMOVE) begin
                    state_next = ST_SHIFT;
                end else if (hit || last_scan) begin
                    state_next = ST_DONE;
                end
            end
            ST_SHIFT: begin
                if (!shift_more) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Datapath and store controls
    always_comb begin
        req_next      = req_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        pos_next      = pos_reg;
        status_next   = status_reg;
        m_data_next   = m_data_reg;
        m_valid_next  = m_valid_reg;
        mem_ctl.we    = 1'b0;
        mem_ctl.waddr = idx_reg;
        mem_ctl.wdata = rd_data;
        mem_ctl.raddr = '0;

        // Drop the result once it is taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    req_next    = s_data;
                    idx_next    = '0;
                    pos_next    = '0;
                    status_next = STAT_OK;
                    unique case (s_data.req_type)
                        REQ_APPEND: begin
                            if (list_full) begin
                                status_next = STAT_FULL;
                            end else begin
                                mem_ctl.we    = 1'b1;
                                mem_ctl.waddr = count_reg[IDX_W-1:0];
                                mem_ctl.wdata = s_data.value;
                                pos_next      = count_reg[IDX_W-1:0];
                                count_next    = count_reg + CNT_W'(1);
                            end
                        end
                        REQ_REMOVE, REQ_FIND: begin
                            if (list_empty) begin
                                status_next = STAT_NOT_FOUND;
                            end
                        end
                        default: begin
                            status_next = STAT_OK;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                // Prefetch the next entry while comparing this one
                mem_ctl.raddr = idx_reg + IDX_W'(1);
                if (hit) begin
                    pos_next    = idx_reg;
                    status_next = STAT_OK;
                end else if (last_scan) begin
                    pos_next    = '0;
                    status_next = STAT_NOT_FOUND;
                end else begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_SHIFT: begin
                // Move entry idx+1 down to idx, fetch idx+2
                mem_ctl.raddr = idx_reg + IDX_W'(2);
                if (shift_more) begin
                    mem_ctl.we    = 1'b1;
                    mem_ctl.waddr = idx_reg;
                    mem_ctl.wdata = rd_data;
                    idx_next      = idx_reg + IDX_W'(1);
                end else begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next           = 1'b1;
                    m_data_next.status     = status_reg;
                    m_data_next.position   = POS_W'(pos_reg);
                    m_data_next.item_count = ITEM_CNT_W'(count_reg);
                end
            end
            default: begin
                mem_ctl.raddr = '0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        req_reg    <= req_next;
        idx_reg    <= idx_next;
        pos_reg    <= pos_next;
        status_reg <= status_next;
        m_data_reg <= m_data_next;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Checks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above capacity");

    a_busy_after_xfer: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer |=> state_reg != ST_IDLE)
        else $error("sequencer idle after a request transfer");

    a_pos_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status != STAT_OK) |-> m_data.position == '0)
        else $error("position not zero on failed request");

    a_scan_count: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_SCAN |=> count_reg == $past(count_reg))
        else $error("count changed during scan");

endmodule

// ----- tb/tb.sv -----
module tb;
    import plarf_pkg::*;

    // Request code the block leaves unused
    localparam logic [1:0] REQ_SPARE = 2'd3;

    localparam int RANDOM_ITEMS = 1350;
    localparam int SETTLE_CYCLES = 2 * DEPTH + 8;
    localparam int QUIET_LIMIT = 4000;

    typedef struct {
        req_t req;
        bit   typed;
        res_t want;
    } dir_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    req_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    res_t m_data;

    // Own copy of the list contents and length
    logic [DATA_W-1:0] list_vals [DEPTH];
    int                list_len = 0;

    res_t     expected_q [$];
    dir_row_t dir_rows [$];
    int       fail_count = 0;
    bit       calm = 1'b0;

    packed_list_append_remove_find_core uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Apply one request to the list copy and return the result it yields
    function automatic res_t apply_request(input req_t req);
        res_t res;
        int   hit;
        int   i;
        res = '0;
        hit = -1;
        for (i = 0; i < list_len; i++) begin
            if (hit < 0 && list_vals[i] == req.value) begin
                hit = i;
            end
        end
        case (req.req_type)
            REQ_APPEND: begin
                if (list_len >= DEPTH) begin
                    res.status = STAT_FULL;
                end else begin
                    list_vals[list_len] = req.value;
                    res.position = POS_W'(list_len);
                    list_len++;
                end
            end
            REQ_REMOVE: begin
                if (hit < 0) begin
                    res.status = STAT_NOT_FOUND;
                end else begin
                    for (i = hit; i < list_len - 1; i++) begin
                        list_vals[i] = list_vals[i + 1];
                    end
                    list_len--;
                    res.position = POS_W'(hit);
                end
            end
            REQ_FIND: begin
                if (hit < 0) begin
                    res.status = STAT_NOT_FOUND;
                end else begin
                    res.position = POS_W'(hit);
                end
            end
            default: ;
        endcase
        res.item_count = ITEM_CNT_W'(list_len);
        return res;
    endfunction

    function automatic void add_row(input logic [1:0] code, input logic [DATA_W-1:0] val,
                                    input bit typed, input logic [1:0] st, input int pos,
                                    input int cnt);
        dir_row_t row;
        row.req.req_type = code;
        row.req.value = val;
        row.typed = typed;
        row.want.status = st;
        row.want.position = POS_W'(pos);
        row.want.item_count = ITEM_CNT_W'(cnt);
        dir_rows = {dir_rows, row};
    endfunction

    // Present one request, hold it until the transfer, then log its outcome
    task automatic send_request(input req_t req, input bit typed, input res_t want);
        res_t predicted;
        while (!calm && $urandom_range(99) < 29) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= req;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        predicted = apply_request(req);
        expected_q = {expected_q, (typed ? want : predicted)};
    endtask

    // Result side: random back-pressure, compare each transfer with the oldest outcome
    always @(posedge aclk) begin
        res_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_q.size() == 0) begin
                fail_count++;
                $display("%0t: result with none outstanding, expected none got %p",
                         $time, m_data);
            end else begin
                want = expected_q.pop_front();
                if (m_data.status !== want.status || m_data.position !== want.position ||
                        m_data.item_count !== want.item_count) begin
                    fail_count++;
                end
                if (m_data.status !== want.status) begin
                    $display("%0t: status expected %0d got %0d",
                             $time, want.status, m_data.status);
                end
                if (m_data.position !== want.position) begin
                    $display("%0t: position expected %0d got %0d",
                             $time, want.position, m_data.position);
                end
                if (m_data.item_count !== want.item_count) begin
                    $display("%0t: item_count expected %0d got %0d",
                             $time, want.item_count, m_data.item_count);
                end
            end
        end
        m_ready <= calm || ($urandom_range(99) >= 29);
    end

    // Watchdog: end the run after too long without any transfer
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("tb failed");
        $finish;
    end

    initial begin
        int               i;
        int               counted;
        int               roll;
        bit               fill;
        req_t             req;
        logic [DATA_W-1:0] val;

        // Directed rows: empty list, boundary values, duplicates, full list, spare code
        add_row(REQ_FIND, 32'h0000_0000, 1, STAT_NOT_FOUND, 0, 0);
        add_row(REQ_REMOVE, 32'h8000_0000, 1, STAT_NOT_FOUND, 0, 0);
        add_row(REQ_SPARE, 32'hFFFF_FFFF, 1, STAT_OK, 0, 0);
        add_row(REQ_APPEND, 32'h8000_0000, 1, STAT_OK, 0, 1);
        add_row(REQ_APPEND, 32'h7FFF_FFFF, 1, STAT_OK, 1, 2);
        add_row(REQ_APPEND, 32'hFFFF_FFFF, 1, STAT_OK, 2, 3);
        add_row(REQ_APPEND, 32'h0000_0000, 1, STAT_OK, 3, 4);
        add_row(REQ_APPEND, 32'hFFFF_FFFF, 1, STAT_OK, 4, 5);
        for (i = 5; i < DEPTH; i++) begin
            add_row(REQ_APPEND, 32'h5A5A_0000 + i, 1, STAT_OK, i, i + 1);
        end
        add_row(REQ_APPEND, 32'h0000_0001, 1, STAT_FULL, 0, DEPTH);
        add_row(REQ_SPARE, 32'h0000_0000, 1, STAT_OK, 0, DEPTH);
        add_row(REQ_FIND, 32'hFFFF_FFFF, 0, STAT_OK, 0, 0);
        add_row(REQ_REMOVE, 32'h8000_0000, 0, STAT_OK, 0, 0);
        add_row(REQ_REMOVE, 32'h5A5A_0000 + DEPTH - 1, 0, STAT_OK, 0, 0);
        add_row(REQ_FIND, 32'h7FFF_FFFF, 0, STAT_OK, 0, 0);

        // Hold reset, then release
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[r]) begin
            send_request(dir_rows[r].req, dir_rows[r].typed, dir_rows[r].want);
        end

        // Random traffic: alternate fill and drain phases, values mostly from the list
        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            roll = $urandom_range(99);
            fill = ((counted / 90) % 2) == 0;
            if (roll < 4) begin
                req.req_type = REQ_SPARE;
            end else if (roll < (fill ? 64 : 29)) begin
                req.req_type = REQ_APPEND;
            end else if (roll < (fill ? 80 : 74)) begin
                req.req_type = REQ_REMOVE;
            end else begin
                req.req_type = REQ_FIND;
            end
            roll = $urandom_range(9);
            if (roll < 6 && list_len > 0) begin
                val = list_vals[$urandom_range(list_len - 1)];
            end else if (roll < 8) begin
                case ($urandom_range(3))
                    0: val = 32'h0000_0000;
                    1: val = 32'hFFFF_FFFF;
                    2: val = 32'h8000_0000;
                    default: val = 32'h7FFF_FFFF;
                endcase
            end else begin
                val = $urandom();
            end
            req.value = val;
            counted++;
            calm = counted >= 600 && counted < 800;
            send_request(req, 1'b0, '0);
        end
        s_valid <= 1'b0;
        calm = 1'b0;

        // Drain outstanding results, then allow late stray transfers to show up
        while (expected_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (fail_count == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
